>>> src/wwvb_tc_pkg.sv
// Shared widths, codes and arithmetic helpers for the WWVB time-code generator.
package wwvb_tc_pkg;

  localparam int unsigned InW  = 56;
  localparam int unsigned OutW = 8;

  // frame symbol codes
  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_ONE  = 2'd1;
  localparam logic [1:0] SYM_MARK = 2'd2;

  // length of the low carrier pulse per symbol, in ms
  localparam logic [9:0] LOW_MS_ZERO = 10'd200;
  localparam logic [9:0] LOW_MS_ONE  = 10'd500;
  localparam logic [9:0] LOW_MS_MARK = 10'd800;

  // x / 10 for any 16-bit x: multiply by 0xCCCD, keep bits above 2^19
  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'h0000_CCCD;
    return p[31:19];
  endfunction

  // x % 10 given q = x / 10; only the low digit bits survive
  function automatic logic [3:0] rem10(input logic [15:0] x, input logic [12:0] q);
    logic [15:0] t;
    t = x - ({q, 3'b000} + {2'b00, q, 1'b0});
    return t[3:0];
  endfunction

endpackage

>>> src/wwvb_time_code_pulse_generator_core.sv
// WWVB time-code generator: time sample in, frame symbol and carrier level out.
//
// One time sample per transfer, one result per sample, in order. A sample can enter
// every clock unless all stages are full and the output stalls; a result leaves when
// the output side is ready. The four register stages are: quotients by ten, remainders
// and second-level quotients, symbol selection, and the carrier compare in the output
// register. Empty stages fill during a stall, so up to four samples are in flight.
// Input tdata, low bit first: hour[4:0], minute[10:5], second[16:11],
// millisecond[26:17], day_of_year[35:27], full_year[49:36], dst_today[50],
// dst_tomorrow[51], zero pad [55:52]. Output tdata: carrier_high[0], symbol[2:1],
// zero pad [7:3].
module wwvb_time_code_pulse_generator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // hour, minute, second, millisecond, day_of_year, full_year, dst_today, dst_tomorrow
  input  logic [wwvb_tc_pkg::InW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // carrier_high, symbol
  output logic [wwvb_tc_pkg::OutW-1:0] m_axis_tdata_o
);
  import wwvb_tc_pkg::*;

  // ---- stage ready chain (bubbles collapse) ----
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  // ---- input unpack ----
  logic [4:0]  in_hr;
  logic [5:0]  in_mn, in_sec;
  logic [9:0]  in_ms;
  logic [8:0]  in_yd;
  logic [13:0] in_yr;
  logic        in_dst0, in_dst1;

  assign in_hr   = s_axis_tdata_i[4:0];
  assign in_mn   = s_axis_tdata_i[10:5];
  assign in_sec  = s_axis_tdata_i[16:11];
  assign in_ms   = s_axis_tdata_i[26:17];
  assign in_yd   = s_axis_tdata_i[35:27];
  assign in_yr   = s_axis_tdata_i[49:36];
  assign in_dst0 = s_axis_tdata_i[50];
  assign in_dst1 = s_axis_tdata_i[51];

  // ---- stage 1: first quotients ----
  logic [12:0] q_mn, q_hr, q_dn, q_yr;
  logic [9:0]  dn;

  assign dn   = 10'(in_yd) + 10'd1;
  assign q_mn = div10(16'(in_mn));
  assign q_hr = div10(16'(in_hr));
  assign q_dn = div10(16'(dn));
  assign q_yr = div10(16'(in_yr));

  logic [5:0]  s1_mn_q, s1_sec_q;
  logic [2:0]  s1_mq_q;
  logic [4:0]  s1_hr_q;
  logic [1:0]  s1_hq_q;
  logic [9:0]  s1_dn_q, s1_ms_q;
  logic [5:0]  s1_dq_q;
  logic [13:0] s1_yr_q;
  logic [10:0] s1_yq_q;
  logic        s1_dst0_q, s1_dst1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_mn_q   <= in_mn;
      s1_mq_q   <= q_mn[2:0];
      s1_hr_q   <= in_hr;
      s1_hq_q   <= q_hr[1:0];
      s1_dn_q   <= dn;
      s1_dq_q   <= q_dn[5:0];
      s1_yr_q   <= in_yr;
      s1_yq_q   <= q_yr[10:0];
      s1_sec_q  <= in_sec;
      s1_ms_q   <= in_ms;
      s1_dst0_q <= in_dst0;
      s1_dst1_q <= in_dst1;
    end
  end

  // ---- stage 2: unit digits and hundreds quotients ----
  logic [3:0]  r_mn, r_hr, r_dn, r_yr;
  logic [12:0] q_dq, q_yq;

  assign r_mn = rem10(16'(s1_mn_q), 13'(s1_mq_q));
  assign r_hr = rem10(16'(s1_hr_q), 13'(s1_hq_q));
  assign r_dn = rem10(16'(s1_dn_q), 13'(s1_dq_q));
  assign r_yr = rem10(16'(s1_yr_q), 13'(s1_yq_q));
  assign q_dq = div10(16'(s1_dq_q));
  assign q_yq = div10(16'(s1_yq_q));

  logic [2:0]  s2_mt_q;
  logic [3:0]  s2_mu_q, s2_hu_q, s2_du_q, s2_yu_q;
  logic [1:0]  s2_ht_q, s2_yr_lo_q;
  logic [5:0]  s2_dq1_q, s2_sec_q;
  logic [2:0]  s2_dq2_q;
  logic [10:0] s2_yq1_q;
  logic [7:0]  s2_yq2_q;
  logic [9:0]  s2_ms_q;
  logic        s2_dst0_q, s2_dst1_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_mt_q    <= s1_mq_q;
      s2_mu_q    <= r_mn;
      s2_ht_q    <= s1_hq_q;
      s2_hu_q    <= r_hr;
      s2_dq1_q   <= s1_dq_q;
      s2_dq2_q   <= q_dq[2:0];
      s2_du_q    <= r_dn;
      s2_yq1_q   <= s1_yq_q;
      s2_yq2_q   <= q_yq[7:0];
      s2_yu_q    <= r_yr;
      s2_yr_lo_q <= s1_yr_q[1:0];
      s2_sec_q   <= s1_sec_q;
      s2_ms_q    <= s1_ms_q;
      s2_dst0_q  <= s1_dst0_q;
      s2_dst1_q  <= s1_dst1_q;
    end
  end

  // ---- stage 3: tens digits, leap rule, symbol select ----
  logic [3:0] dt, yt;
  logic       leap;
  logic [1:0] sym;

  assign dt = rem10(16'(s2_dq1_q), 13'(s2_dq2_q));
  assign yt = rem10(16'(s2_yq1_q), 13'(s2_yq2_q));
  // divisible by 4, and not a century unless the century count is divisible by 4
  assign leap = (s2_yr_lo_q == 2'b00) &&
                (!((s2_yu_q == 4'd0) && (yt == 4'd0)) || (s2_yq2_q[1:0] == 2'b00));

  always_comb begin
    sym = SYM_ZERO;
    case (s2_sec_q)
      6'd0, 6'd9, 6'd19, 6'd29, 6'd39, 6'd49, 6'd59: sym = SYM_MARK;
      6'd1:  sym = {1'b0, s2_mt_q[2]};
      6'd2:  sym = {1'b0, s2_mt_q[1]};
      6'd3:  sym = {1'b0, s2_mt_q[0]};
      6'd5:  sym = {1'b0, s2_mu_q[3]};
      6'd6:  sym = {1'b0, s2_mu_q[2]};
      6'd7:  sym = {1'b0, s2_mu_q[1]};
      6'd8:  sym = {1'b0, s2_mu_q[0]};
      6'd12: sym = {1'b0, s2_ht_q[1]};
      6'd13: sym = {1'b0, s2_ht_q[0]};
      6'd15: sym = {1'b0, s2_hu_q[3]};
      6'd16: sym = {1'b0, s2_hu_q[2]};
      6'd17: sym = {1'b0, s2_hu_q[1]};
      6'd18: sym = {1'b0, s2_hu_q[0]};
      6'd22: sym = {1'b0, s2_dq2_q[1]};
      6'd23: sym = {1'b0, s2_dq2_q[0]};
      6'd25: sym = {1'b0, dt[3]};
      6'd26: sym = {1'b0, dt[2]};
      6'd27: sym = {1'b0, dt[1]};
      6'd28: sym = {1'b0, dt[0]};
      6'd30: sym = {1'b0, s2_du_q[3]};
      6'd31: sym = {1'b0, s2_du_q[2]};
      6'd32: sym = {1'b0, s2_du_q[1]};
      6'd33: sym = {1'b0, s2_du_q[0]};
      6'd36, 6'd38: sym = SYM_ONE;   // UT1 sign fixed at plus
      6'd45: sym = {1'b0, yt[3]};
      6'd46: sym = {1'b0, yt[2]};
      6'd47: sym = {1'b0, yt[1]};
      6'd48: sym = {1'b0, yt[0]};
      6'd50: sym = {1'b0, s2_yu_q[3]};
      6'd51: sym = {1'b0, s2_yu_q[2]};
      6'd52: sym = {1'b0, s2_yu_q[1]};
      6'd53: sym = {1'b0, s2_yu_q[0]};
      6'd55: sym = {1'b0, leap};
      6'd57: sym = {1'b0, s2_dst1_q};
      6'd58: sym = {1'b0, s2_dst0_q};
      6'd60, 6'd61, 6'd62, 6'd63: sym = SYM_MARK;  // leap second and beyond
      default: sym = SYM_ZERO;
    endcase
  end

  logic [1:0] s3_sym_q;
  logic [9:0] s3_ms_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_sym_q <= sym;
      s3_ms_q  <= s2_ms_q;
    end
  end

  // ---- stage 4: carrier compare into the output register ----
  logic [9:0] low_ms;
  logic       carrier;

  always_comb begin
    case (s3_sym_q)
      SYM_ZERO: low_ms = LOW_MS_ZERO;
      SYM_ONE:  low_ms = LOW_MS_ONE;
      default:  low_ms = LOW_MS_MARK;
    endcase
  end

  assign carrier = (s3_ms_q >= low_ms);

  logic [OutW-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_data_q <= {{(OutW-3){1'b0}}, s3_sym_q, carrier};
    end
  end

  // ---- valid bits ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> src/wwvb_tc_chk.sv
// Port-level checks for the WWVB time-code generator, bound to the top level.
module wwvb_tc_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [wwvb_tc_pkg::InW-1:0]  s_axis_tdata_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [wwvb_tc_pkg::OutW-1:0] m_axis_tdata_o
);
  import wwvb_tc_pkg::*;

  // no result can appear right after reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

  // symbol is a legal code and the pad bits stay zero
  a_symbol_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2:1] != 2'd3) && (m_axis_tdata_o[OutW-1:3] == '0))
    else $error("illegal symbol or nonzero pad");

  // an empty output register frees every stage, so the input side can take a transfer
  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while pipeline output is empty");

endmodule

bind wwvb_time_code_pulse_generator_core wwvb_tc_chk u_wwvb_tc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

>>> verif/testbench.sv
// Testbench for the WWVB time-code pulse generator: directed and random samples, self-checked.
`timescale 1ns / 1ps

module testbench;
  import wwvb_tc_pkg::*;

  typedef struct {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [8:0]  day_of_year;
    logic [13:0] full_year;
    logic        dst_today;
    logic        dst_tomorrow;
  } time_sample_t;

  typedef struct {
    logic       carrier_high;
    logic [1:0] symbol;
  } pulse_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  // hour, minute, second, millisecond, day_of_year, full_year, dst_today, dst_tomorrow
  logic [InW-1:0]  s_axis_tdata_i = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  // carrier_high, symbol
  logic [OutW-1:0] m_axis_tdata_o;

  pulse_t pending_pulses[$];
  int     mismatch_count = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;

  wwvb_time_code_pulse_generator_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [1:0] digit_symbol(int digit, int pos);
    return ((digit >> pos) & 1) ? SYM_ONE : SYM_ZERO;
  endfunction

  // Expected frame symbol and carrier level for one time sample
  function automatic pulse_t predict_pulse(time_sample_t s);
    int         day_num, yr;
    int         min_tens, min_units, hr_tens, hr_units;
    int         day_hund, day_tens, day_units, yr_tens, yr_units;
    bit         is_leap;
    logic [1:0] sym;
    logic [9:0] low_ms;
    pulse_t     p;
    day_num   = int'(s.day_of_year) + 1;
    yr        = int'(s.full_year);
    min_tens  = int'(s.minute) / 10;
    min_units = int'(s.minute) % 10;
    hr_tens   = int'(s.hour) / 10;
    hr_units  = int'(s.hour) % 10;
    day_hund  = day_num / 100;
    day_tens  = (day_num / 10) % 10;
    day_units = day_num % 10;
    yr_tens   = (yr / 10) % 10;
    yr_units  = yr % 10;
    is_leap   = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (s.second)
      0, 9, 19, 29, 39, 49, 59: sym = SYM_MARK;
      1:  sym = digit_symbol(min_tens, 2);
      2:  sym = digit_symbol(min_tens, 1);
      3:  sym = digit_symbol(min_tens, 0);
      5:  sym = digit_symbol(min_units, 3);
      6:  sym = digit_symbol(min_units, 2);
      7:  sym = digit_symbol(min_units, 1);
      8:  sym = digit_symbol(min_units, 0);
      12: sym = digit_symbol(hr_tens, 1);
      13: sym = digit_symbol(hr_tens, 0);
      15: sym = digit_symbol(hr_units, 3);
      16: sym = digit_symbol(hr_units, 2);
      17: sym = digit_symbol(hr_units, 1);
      18: sym = digit_symbol(hr_units, 0);
      22: sym = digit_symbol(day_hund, 1);
      23: sym = digit_symbol(day_hund, 0);
      25: sym = digit_symbol(day_tens, 3);
      26: sym = digit_symbol(day_tens, 2);
      27: sym = digit_symbol(day_tens, 1);
      28: sym = digit_symbol(day_tens, 0);
      30: sym = digit_symbol(day_units, 3);
      31: sym = digit_symbol(day_units, 2);
      32: sym = digit_symbol(day_units, 1);
      33: sym = digit_symbol(day_units, 0);
      36, 38: sym = SYM_ONE;  // UT1 sign "+"
      45: sym = digit_symbol(yr_tens, 3);
      46: sym = digit_symbol(yr_tens, 2);
      47: sym = digit_symbol(yr_tens, 1);
      48: sym = digit_symbol(yr_tens, 0);
      50: sym = digit_symbol(yr_units, 3);
      51: sym = digit_symbol(yr_units, 2);
      52: sym = digit_symbol(yr_units, 1);
      53: sym = digit_symbol(yr_units, 0);
      55: sym = is_leap ? SYM_ONE : SYM_ZERO;
      57: sym = s.dst_tomorrow ? SYM_ONE : SYM_ZERO;
      58: sym = s.dst_today ? SYM_ONE : SYM_ZERO;
      // leap second and anything past it go out as markers
      default: sym = (s.second >= 6'd60) ? SYM_MARK : SYM_ZERO;
    endcase
    case (sym)
      SYM_ZERO: low_ms = LOW_MS_ZERO;
      SYM_ONE:  low_ms = LOW_MS_ONE;
      default:  low_ms = LOW_MS_MARK;
    endcase
    p.carrier_high = (s.millisecond >= low_ms);
    p.symbol       = sym;
    return p;
  endfunction

  function automatic time_sample_t make_sample(int h, int m, int sec, int ms, int yd, int yr,
                                               int dst0, int dst1);
    time_sample_t s;
    s.hour         = h[4:0];
    s.minute       = m[5:0];
    s.second       = sec[5:0];
    s.millisecond  = ms[9:0];
    s.day_of_year  = yd[8:0];
    s.full_year    = yr[13:0];
    s.dst_today    = dst0[0];
    s.dst_tomorrow = dst1[0];
    return s;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens
  task automatic send_sample(input time_sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0000, s.dst_tomorrow, s.dst_today, s.full_year, s.day_of_year,
                        s.millisecond, s.second, s.minute, s.hour};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_pulses.push_back(predict_pulse(s));
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    pulse_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_pulses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result: carrier=%0b symbol=%0d", $realtime,
                   m_axis_tdata_o[0], m_axis_tdata_o[2:1]);
      end else begin
        want = pending_pulses.pop_front();
        if (m_axis_tdata_o[0] !== want.carrier_high || m_axis_tdata_o[2:1] !== want.symbol) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] mismatch: carrier exp %0b got %0b, symbol exp %0d got %0d",
                     $realtime, want.carrier_high, m_axis_tdata_o[0], want.symbol,
                     m_axis_tdata_o[2:1]);
        end
      end
    end
  end

  task automatic test_directed_cases();
    // field extremes
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample(23, 59, 59, 999, 365, 9999, 1, 1));
    send_sample(make_sample(31, 63, 63, 1023, 511, 16383, 1, 1));
    // leap second, and seconds past it
    send_sample(make_sample(12, 30, 60, 799, 100, 2024, 0, 0));
    send_sample(make_sample(12, 30, 60, 800, 100, 2024, 0, 0));
    send_sample(make_sample(12, 30, 61, 500, 100, 2024, 0, 0));
    send_sample(make_sample(12, 30, 62, 900, 100, 2024, 0, 0));
    // millisecond past the second keeps carrier high
    send_sample(make_sample(0, 0, 4, 1000, 0, 2025, 0, 0));
    // pulse width edges for zero and one
    send_sample(make_sample(5, 17, 4, 199, 40, 2025, 0, 0));
    send_sample(make_sample(5, 17, 4, 200, 40, 2025, 0, 0));
    send_sample(make_sample(5, 17, 36, 499, 40, 2025, 0, 0));
    send_sample(make_sample(5, 17, 36, 500, 40, 2025, 0, 0));
    send_sample(make_sample(5, 17, 37, 300, 40, 2025, 0, 0));
    send_sample(make_sample(5, 17, 38, 300, 40, 2025, 0, 0));
    // Gregorian leap rule
    send_sample(make_sample(1, 2, 55, 600, 3, 2000, 0, 0));
    send_sample(make_sample(1, 2, 55, 600, 3, 1900, 0, 0));
    send_sample(make_sample(1, 2, 55, 600, 3, 2024, 0, 0));
    send_sample(make_sample(1, 2, 55, 600, 3, 2023, 0, 0));
    send_sample(make_sample(1, 2, 55, 600, 3, 0, 0, 0));
    // DST bits
    send_sample(make_sample(2, 0, 57, 600, 69, 2025, 0, 1));
    send_sample(make_sample(2, 0, 58, 600, 69, 2025, 1, 0));
    // out-of-range digits lose their high bits
    send_sample(make_sample(31, 0, 12, 600, 0, 2025, 0, 0));
    send_sample(make_sample(0, 63, 1, 600, 0, 2025, 0, 0));
    send_sample(make_sample(0, 0, 22, 600, 511, 2025, 0, 0));
    send_sample(make_sample(0, 0, 23, 600, 511, 2025, 0, 0));
  endtask

  task automatic run_random_samples(input int count);
    time_sample_t s;
    int           pick;
    int           edges[6] = '{200, 500, 800, 100, 400, 0};
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        s = make_sample($urandom_range(23), $urandom_range(59), $urandom_range(60),
                        $urandom_range(999), $urandom_range(365), $urandom_range(9999),
                        $urandom_range(1), $urandom_range(1));
        // land near a pulse edge
        if (pick >= 70)
          s.millisecond = 10'(edges[$urandom_range(2)] + $urandom_range(2) - 1);
      end else begin
        s = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
      end
      send_sample(s);
    end
  endtask

  task automatic test_no_idling();
    idle_pct  = 0;
    stall_pct = 0;
    run_random_samples(150);
  endtask

  task automatic test_sender_idle();
    idle_pct  = 75;
    stall_pct = 0;
    run_random_samples(150);
  endtask

  task automatic test_receiver_stall();
    idle_pct  = 0;
    stall_pct = 75;
    run_random_samples(150);
  endtask

  task automatic test_both_idle();
    idle_pct  = 32;
    stall_pct = 32;
    run_random_samples(150);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> wwvb_time_code_pulse_generator_core.f
src/wwvb_tc_pkg.sv
src/wwvb_time_code_pulse_generator_core.sv
src/wwvb_tc_chk.sv
verif/testbench.sv
